// ===== hdl/pcgbr_pkg.sv =====
// Shared types, constants and output-mixing function of the PCG32 bounded generator.
package pcgbr_pkg;

    localparam int STATE_W   = 64;
    localparam int WORD_W    = 32;
    localparam int BOUND_W   = 31;
    localparam int SEQ_W     = 63;
    localparam int CFG_IDX_W = 1;

    // LCG multiplier
    localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;

    // XSH-RR output taps
    localparam int XS_SHIFT = 18;
    localparam int XS_DROP  = 27;
    localparam int ROT_POS  = 59;

    // multiplier digit size and step count
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_STEPS   = STATE_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // remainder unit: one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(WORD_W);

    // input actions
    localparam logic ACT_RESEED = 1'b0;
    localparam logic ACT_DRAW   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_STEP,
        ST_SEED_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    // XSH-RR: xorshift high bits, then rotate right by the top five state bits
    function automatic logic [WORD_W-1:0] pcgbr_xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  x;
        logic [WORD_W-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        x     = (s >> XS_SHIFT) ^ s;
        mixed = x[XS_DROP +: WORD_W];
        rot   = s[ROT_POS +: 5];
        dbl   = {mixed, mixed} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

// ===== hdl/pcgbr_if.sv =====
// Valid/ready channel interfaces: draw requests, results and register writes.
interface pcgbr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [pcgbr_pkg::BOUND_W-1:0] bound;
    modport source (output valid, action, bound, input ready);
    modport sink   (input valid, action, bound, output ready);
endinterface

interface pcgbr_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcgbr_pkg::WORD_W-1:0]  raw_word;
    logic [pcgbr_pkg::BOUND_W-1:0] value;
    logic                          bound_error;
    modport source (output valid, raw_word, value, bound_error, input ready);
    modport sink   (input valid, raw_word, value, bound_error, output ready);
endinterface

interface pcgbr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pcgbr_pkg::CFG_IDX_W-1:0] index;
    logic [pcgbr_pkg::STATE_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pcgbr_mul.sv =====
// Iterative LCG step unit: state * LCG_MULT + addend mod 2^64, one 16-bit digit per cycle.
module pcgbr_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcgbr_pkg::STATE_W-1:0] i_mcand,
    input  logic [pcgbr_pkg::STATE_W-1:0] i_addend,
    output logic                          o_done,
    output logic [pcgbr_pkg::STATE_W-1:0] o_product
);
    import pcgbr_pkg::*;

    logic                              r_busy;
    logic                              r_done;
    logic [MUL_CNT_W-1:0]              r_cnt;
    logic [STATE_W-1:0]                r_mcand;
    logic [STATE_W-1:0]                r_mult;
    logic [STATE_W-1:0]                r_acc;
    logic [STATE_W+MUL_DIGIT_W-1:0]    w_pp;

    // digit times shifted constant, only low 64 bits matter
    assign w_pp = r_mcand[MUL_DIGIT_W-1:0] * r_mult;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mult  <= LCG_MULT;
            r_acc   <= i_addend;
        end else if (r_busy) begin
            r_mcand <= r_mcand >> MUL_DIGIT_W;
            r_mult  <= r_mult << MUL_DIGIT_W;
            r_acc   <= r_acc + w_pp[STATE_W-1:0];
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== hdl/pcgbr_div.sv =====
// Restoring remainder unit: 32-bit word modulo 31-bit bound, one bit per cycle.
module pcgbr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcgbr_pkg::WORD_W-1:0]  i_dividend,
    input  logic [pcgbr_pkg::BOUND_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [pcgbr_pkg::BOUND_W-1:0] o_rem
);
    import pcgbr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_num;
    logic [BOUND_W-1:0]   r_dsr;
    logic [BOUND_W-1:0]   r_rem;
    logic [WORD_W-1:0]    w_trial;
    logic [WORD_W-1:0]    w_diff;
    logic                 w_fits;

    assign w_trial = {r_rem, r_num[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits in 31 bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_fits ? w_diff[BOUND_W-1:0] : w_trial[BOUND_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/pcg32_bounded_random.sv =====
// Top level of the PCG32 XSH-RR generator with bounded draws.
// PCG32 XSH-RR random number generator. Each input transaction yields exactly one
// result transaction. A draw (action 1) forms the 32-bit output word from the
// current state, advances the 64-bit LCG once and returns the word and the word
// modulo bound; bound zero still advances the generator but returns value 0 with
// bound_error set. A reseed (action 0) restarts from init_state / init_sequence
// (increment = init_sequence<<1 | 1) and returns all zeros. Registers are written
// through the config channel, which is always ready; write them only while idle.
// A draw runs one LCG step and then the remainder unit, a draw with bound zero
// skips the remainder, and a reseed runs two steps with init_state added between
// them. The input is ready again in the same cycle as the result turns valid,
// later while the receiver leaves the result register full. Each LCG step passes
// a launch state, then the 16-bit digits on the shared multiply-accumulate unit,
// then its done flag. The remainder comes from a restoring unit that resolves
// one bit per cycle over the 32 bits of the word, then raises its done flag.
// The input is ready only in the idle state; a finished result sits in an output
// register, so a new transaction can start while it waits.
module pcg32_bounded_random (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcgbr_in_if.sink     i_in,
    pcgbr_out_if.source  o_out,
    pcgbr_cfg_if.sink    i_cfg
);
    import pcgbr_pkg::*;

    t_state               r_state;
    t_state               n_state;

    // generator state and configuration
    logic [STATE_W-1:0]   r_lcg;
    logic [STATE_W-1:0]   r_inc;
    logic [STATE_W-1:0]   r_init_state;
    logic [SEQ_W-1:0]     r_init_seq;

    // current transaction
    logic                 r_is_draw;
    logic                 r_seed_pass;   // reseed: second LCG step underway
    logic [BOUND_W-1:0]   r_bound;
    logic [WORD_W-1:0]    r_word;

    // result register
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_word;
    logic [BOUND_W-1:0]   r_out_value;
    logic                 r_out_err;

    // sequencer controls
    logic                 w_accept;
    logic                 w_mul_start;
    logic                 w_mul_done;
    logic [STATE_W-1:0]   w_product;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [BOUND_W-1:0]   w_rem;
    logic                 w_bound_zero;
    logic                 w_out_free;
    logic                 w_out_load;

    assign w_bound_zero = (r_bound == '0);
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_accept     = i_in.valid && i_in.ready;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;

    pcgbr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (r_lcg),
        .i_addend  (r_inc | STATE_W'(1)),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    pcgbr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_word),
        .i_divisor  (r_bound),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (w_mul_done) begin
                    if (r_is_draw) n_state = w_bound_zero ? ST_DONE : ST_DIV;
                    else           n_state = r_seed_pass ? ST_DONE : ST_SEED_ADD;
                end
            end
            ST_SEED_ADD: begin
                n_state = ST_LAUNCH;
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_mul_start = (r_state == ST_LAUNCH);
        w_div_start = (r_state == ST_STEP) && w_mul_done && r_is_draw && !w_bound_zero;
        w_out_load  = (r_state == ST_DONE) && w_out_free;
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lcg        <= '0;
            r_inc        <= '0;
            r_init_state <= '0;
            r_init_seq   <= '0;
            r_out_valid  <= 1'b0;
            r_seed_pass  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_INIT_STATE: r_init_state <= i_cfg.data;
                    REG_INIT_SEQ:   r_init_seq   <= i_cfg.data[SEQ_W-1:0];
                    default:        ;
                endcase
            end

            if (w_accept) begin
                r_seed_pass <= 1'b0;
                if (i_in.action == ACT_RESEED) begin
                    r_lcg <= '0;
                    r_inc <= {r_init_seq, 1'b1};
                end
            end

            if ((r_state == ST_STEP) && w_mul_done) r_lcg <= w_product;

            if (r_state == ST_SEED_ADD) begin
                r_lcg       <= r_lcg + r_init_state;
                r_seed_pass <= 1'b1;
            end

            if (w_out_load)       r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_draw <= (i_in.action == ACT_DRAW);
            r_bound   <= i_in.bound;
            // output word comes from the state before the step
            r_word    <= pcgbr_xsh_rr(r_lcg);
        end
        if (w_out_load) begin
            if (!r_is_draw) begin
                r_out_word  <= '0;
                r_out_value <= '0;
                r_out_err   <= 1'b0;
            end else if (w_bound_zero) begin
                r_out_word  <= r_word;
                r_out_value <= '0;
                r_out_err   <= 1'b1;
            end else begin
                r_out_word  <= r_word;
                r_out_value <= w_rem;
                r_out_err   <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.raw_word    = r_out_word;
    assign o_out.value       = r_out_value;
    assign o_out.bound_error = r_out_err;

endmodule
